FILE: hdl/lasc_pkg.sv
// Shared constants, types and helpers for the load aggregation superposition core.
`timescale 1ns / 1ps
`default_nettype none
package lasc_pkg;

    // Row geometry
    localparam int NUM_CELLS = 32;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);

    // Field widths
    localparam int Q_W    = 32;
    localparam int G_W    = 32;
    localparam int IDX_W  = 5;
    localparam int CPL_W  = 6;
    localparam int K_W    = 5;
    localparam int DT_W   = 48;
    localparam int FRAC_W = 16;

    // Multiply-accumulate widths: (g[j]-g[j-1]) is one bit wider than g
    localparam int DG_W   = G_W + 1;
    localparam int PROD_W = DG_W + Q_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int ACC_W  = TERM_W + CELL_W;

    // Stream packing
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_CPL = 1'b0;

    // Reset and limit values
    localparam logic [CPL_W-1:0] CPL_RESET = CPL_W'(4);
    localparam logic [K_W-1:0]   K_MAX     = '1;

    // Item kinds carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Width level of a cell: k = floor(j / cpl), r = j mod cpl
    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [CPL_W-1:0] r;
    } t_lvl;

    // Controls broadcast to every cell
    typedef struct packed {
        logic age;
        logic rot;
    } t_cell_ctl;

    // Controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic issue;
        logic last;
    } t_mac_ctl;

    // Level of the following cell: bump k (saturating) once r reaches cpl
    function automatic t_lvl lvl_next(input t_lvl cur, input logic [CPL_W-1:0] cpl);
        t_lvl               nxt;
        logic [CPL_W:0]     r_inc;
        r_inc = {1'b0, cur.r} + (CPL_W+1)'(1);
        if (r_inc >= {1'b0, cpl}) begin
            nxt.r = '0;
            nxt.k = (cur.k == K_MAX) ? K_MAX : cur.k + K_W'(1);
        end else begin
            nxt.r = r_inc[CPL_W-1:0];
            nxt.k = cur.k;
        end
        return nxt;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/lasc_cell.sv
// One cell of the aggregation row: holds a load and a response factor.
`timescale 1ns / 1ps
`default_nettype none
module lasc_cell import lasc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic                   i_g_wr,
    input  wire logic signed [G_W-1:0]  i_g_wdata,
    input  wire logic [CPL_W-1:0]       i_cpl,
    input  wire t_lvl                   i_lvl,
    output t_lvl                        o_lvl,
    input  wire logic signed [Q_W-1:0]  i_prev_q,
    input  wire logic signed [Q_W-1:0]  i_next_q,
    input  wire logic signed [G_W-1:0]  i_next_g,
    output logic signed [Q_W-1:0]       o_q,
    output logic signed [G_W-1:0]       o_g
);

    logic signed [Q_W-1:0] r_q;
    logic signed [G_W-1:0] r_g;
    t_lvl                  r_lvl;

    logic signed [Q_W-1:0] w_own_sh;
    logic signed [Q_W-1:0] w_prev_sh;
    logic signed [Q_W+1:0] w_sum;
    logic signed [Q_W-1:0] w_aged;

    // Age: q - (q >>> k) + (q_prev >>> k), clamped to 32 bits
    always_comb begin
        w_own_sh  = r_q >>> r_lvl.k;
        w_prev_sh = i_prev_q >>> r_lvl.k;
        w_sum     = (Q_W+2)'(r_q) - (Q_W+2)'(w_own_sh) + (Q_W+2)'(w_prev_sh);
        if (w_sum > $signed({3'b000, {(Q_W-1){1'b1}}})) begin
            w_aged = {1'b0, {(Q_W-1){1'b1}}};
        end else if (w_sum < $signed({3'b111, {(Q_W-1){1'b0}}})) begin
            w_aged = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            w_aged = w_sum[Q_W-1:0];
        end
    end

    // Hold the level position, age on a step, rotate during the sweep, else take a written response factor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= '0;
            r_g   <= '0;
            r_lvl <= '0;
        end else begin
            r_lvl <= i_lvl;
            if (i_ctl.age) begin
                r_q <= w_aged;
            end else if (i_ctl.rot) begin
                r_q <= i_next_q;
            end
            if (i_ctl.rot) begin
                r_g <= i_next_g;
            end else if (i_g_wr) begin
                r_g <= i_g_wdata;
            end
        end
    end

    assign o_lvl = lvl_next(r_lvl, i_cpl);
    assign o_q   = r_q;
    assign o_g   = r_g;

endmodule
`default_nettype wire

FILE: hdl/lasc_mac.sv
// Shared multiply-accumulate for the superposition sum, with 48-bit saturation.
`timescale 1ns / 1ps
`default_nettype none
module lasc_mac import lasc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_mac_ctl               i_ctl,
    input  wire logic signed [Q_W-1:0]  i_q,
    input  wire logic signed [G_W-1:0]  i_g,
    output logic [DT_W-1:0]             o_delta,
    output logic                        o_sat,
    output logic                        o_done
);

    logic signed [G_W-1:0]    r_prev_g;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_plast;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [DG_W-1:0]   w_dg;
    logic signed [TERM_W-1:0] w_term;
    logic [ACC_W-DT_W:0]      w_hi;
    logic                     w_ovf;

    // Difference of neighbouring response factors
    assign w_dg   = DG_W'(i_g) - DG_W'(r_prev_g);
    // Q32.32 product down to Q32.16, rounding toward minus infinity
    assign w_term = r_prod[PROD_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_pv    <= i_ctl.issue;
            r_plast <= i_ctl.issue && i_ctl.last;
            if (i_ctl.start) begin
                r_done <= 1'b0;
            end else if (r_pv && r_plast) begin
                r_done <= 1'b1;
            end
        end
    end

    // Multiply stage, then accumulate stage
    always_ff @(posedge i_clk) begin
        r_prod <= w_dg * i_q;
        if (i_ctl.start) begin
            r_prev_g <= '0;
            r_acc    <= '0;
        end else begin
            if (i_ctl.issue) begin
                r_prev_g <= i_g;
            end
            if (r_pv) begin
                r_acc <= r_acc + ACC_W'(w_term);
            end
        end
    end

    // Clip to the signed 48-bit range
    assign w_hi  = r_acc[ACC_W-1:DT_W-1];
    assign w_ovf = !((&w_hi) || !(|w_hi));

    always_comb begin
        if (!w_ovf) begin
            o_delta = r_acc[DT_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_delta = {1'b1, {(DT_W-1){1'b0}}};
        end else begin
            o_delta = {1'b0, {(DT_W-1){1'b1}}};
        end
    end

    assign o_sat  = w_ovf;
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: hdl/load_aggregation_superposition_core.sv
// Top level of the load aggregation superposition core: stream ports, APB register, control.
`timescale 1ns / 1ps
`default_nettype none
// A load item (tuser = 0) writes one response factor into the cell named by its index and is
// taken with no result and without leaving the idle state. A step item (tuser = 1) ages the
// whole row of NUM_CELLS cells in the cycle it is accepted, puts the new load into cell 0, and
// then rotates the row once round past a single shared multiply-accumulate, one cell per cycle;
// its result goes to the output register once the sum is complete and that register is free,
// and only then is the next item taken. Items are taken one at a time, but a new item is
// accepted while the previous result still waits in the output register. Each cell learns its
// width level from its neighbour, so after reset and after every write of the level-size
// register the block takes no item until a settle counter has run down, while that
// information travels down the row.
module load_aggregation_superposition_core import lasc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // [4:0] index, [36:5] response_value, [68:37] load_value, [71:69] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [0] op
    input  wire logic                   i_s_tuser,
    // Output stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [47:0] delta_temp
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // [0] saturated
    output logic                        o_m_tuser,
    // Configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [CPL_W-1:0]      r_cpl;
    logic [CELL_W-1:0]     r_cnt;
    logic [CELL_W-1:0]     n_cnt;
    logic [CNT_W-1:0]      r_settle;
    logic                  r_out_v;
    logic [DT_W-1:0]       r_out_data;
    logic                  r_out_sat;

    logic                  w_op;
    logic [IDX_W-1:0]      w_index;
    logic signed [G_W-1:0] w_resp;
    logic signed [Q_W-1:0] w_load;
    logic                  w_accept;
    logic                  w_step;
    logic                  w_ldg;
    logic                  w_cfg_wr;
    logic [CPL_W-1:0]      w_cpl_eff;
    logic                  w_last;
    logic                  w_out_load;

    t_cell_ctl             w_cell_ctl;
    t_mac_ctl              w_mac_ctl;
    logic [DT_W-1:0]       w_delta;
    logic                  w_sat;
    logic                  w_mac_done;

    logic signed [Q_W-1:0] w_q   [NUM_CELLS];
    logic signed [G_W-1:0] w_g   [NUM_CELLS];
    t_lvl                  w_lvl [NUM_CELLS+1];

    // Unpack the input item
    assign w_op    = i_s_tuser;
    assign w_index = i_s_tdata[IDX_W-1:0];
    assign w_resp  = i_s_tdata[IDX_W+G_W-1:IDX_W];
    assign w_load  = i_s_tdata[IDX_W+G_W+Q_W-1:IDX_W+G_W];

    assign o_s_tready = (r_state == S_IDLE) && (r_settle == '0);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_step     = w_accept && (w_op == OP_STEP);
    assign w_ldg      = w_accept && (w_op == OP_LOAD);

    // Register access
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CPL) ? APB_DW'(r_cpl) : '0;
    assign w_cpl_eff = (r_cpl == '0) ? CPL_W'(1) : r_cpl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpl    <= CPL_RESET;
            r_settle <= CNT_W'(NUM_CELLS);
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_CPL)) begin
                r_cpl    <= pwdata[CPL_W-1:0];
                r_settle <= CNT_W'(NUM_CELLS);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - CNT_W'(1);
            end
        end
    end

    // Row of cells; the level position enters at cell 0
    assign w_lvl[0]       = '0;
    assign w_cell_ctl.age = w_step;
    assign w_cell_ctl.rot = (r_state == S_RUN);

    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        lasc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_cell_ctl),
            .i_g_wr    (w_ldg && (int'(w_index) == j)),
            .i_g_wdata (w_resp),
            .i_cpl     (w_cpl_eff),
            .i_lvl     (w_lvl[j]),
            .o_lvl     (w_lvl[j+1]),
            .i_prev_q  ((j == 0) ? w_load : w_q[(j == 0) ? 0 : j-1]),
            .i_next_q  (w_q[(j+1) % NUM_CELLS]),
            .i_next_g  (w_g[(j+1) % NUM_CELLS]),
            .o_q       (w_q[j]),
            .o_g       (w_g[j])
        );
    end

    // Shared multiply-accumulate reads cell 0 as the row rotates
    assign w_last          = (r_cnt == CELL_W'(NUM_CELLS-1));
    assign w_mac_ctl.start = w_step;
    assign w_mac_ctl.issue = (r_state == S_RUN);
    assign w_mac_ctl.last  = w_last;

    lasc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_q     (w_q[0]),
        .i_g     (w_g[0]),
        .o_delta (w_delta),
        .o_sat   (w_sat),
        .o_done  (w_mac_done)
    );

    // Sequencer
    assign w_out_load = (r_state == S_WAIT) && w_mac_done && (!r_out_v || i_m_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_step) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + CELL_W'(1);
                if (w_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_delta;
            r_out_sat  <= w_sat;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

    // A step item starts the rotation sweep in the next cycle
    a_step_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> (r_state == S_RUN))
        else $error("step item did not start the sweep");

    // A result appears only on leaving the wait state with the sum complete
    a_out_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_mac_done && (r_state == S_WAIT))
        else $error("result loaded before the sum completed");

    // A clipped result sits at one end of the 48-bit range
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata == {1'b0, {(DT_W-1){1'b1}}}) || (o_m_tdata == {1'b1, {(DT_W-1){1'b0}}}))
        else $error("saturated flag set on an unclipped value");

    // The sweep ends after the last cell of the row
    a_sweep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && w_last) |=> (r_state == S_WAIT))
        else $error("sweep did not end after the last cell");

endmodule
`default_nettype wire
